>>> design/cpu8alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_pkg: shared types and constants of the 8-bit ALU register step
// Operation codes, the register file record and the status byte packing.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

	// Operation codes carried on the command channel.
	typedef enum logic [5:0] {
		OP_ADC      = 6'd0,
		OP_SBC      = 6'd1,
		OP_AND      = 6'd2,
		OP_ORA      = 6'd3,
		OP_EOR      = 6'd4,
		OP_BIT      = 6'd5,
		OP_CMP      = 6'd6,
		OP_CPX      = 6'd7,
		OP_CPY      = 6'd8,
		OP_INX      = 6'd9,
		OP_INY      = 6'd10,
		OP_DEX      = 6'd11,
		OP_DEY      = 6'd12,
		OP_INC_MEM  = 6'd13,
		OP_DEC_MEM  = 6'd14,
		OP_TAX      = 6'd15,
		OP_TAY      = 6'd16,
		OP_TXA      = 6'd17,
		OP_TXS      = 6'd18,
		OP_TYA      = 6'd19,
		OP_ASL_A    = 6'd20,
		OP_ASL_MEM  = 6'd21,
		OP_LSR_A    = 6'd22,
		OP_LSR_MEM  = 6'd23,
		OP_ROL_A    = 6'd24,
		OP_ROL_MEM  = 6'd25,
		OP_ROR_A    = 6'd26,
		OP_ROR_MEM  = 6'd27,
		OP_LDA      = 6'd28,
		OP_LDX      = 6'd29,
		OP_LDY      = 6'd30,
		OP_LD_STAT  = 6'd31,
		OP_SEC      = 6'd32,
		OP_SEI      = 6'd33,
		OP_CLC      = 6'd34,
		OP_CLD      = 6'd35
	} op_e;

	// Architectural register file of the execute stage.
	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic       n;
		logic       v;
		logic       d;
		logic       i;
		logic       z;
		logic       c;
	} regs_t;

	// Register file after reset: everything clear except the I flag.
	localparam regs_t RegsReset = '{
		acc: 8'h00, x: 8'h00, y: 8'h00, sp: 8'h00,
		n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0
	};

	// Status byte bit positions (N V 1 0 D I Z C).
	localparam int unsigned StatN = 7;
	localparam int unsigned StatV = 6;
	localparam int unsigned StatOne = 5;
	localparam int unsigned StatZero = 4;
	localparam int unsigned StatD = 3;
	localparam int unsigned StatI = 2;
	localparam int unsigned StatZ = 1;
	localparam int unsigned StatC = 0;

	// Pack the flags into the status byte; bit 5 reads as one, bit 4 as zero.
	function automatic logic [7:0] pack_status(input regs_t r);
		pack_status = {r.n, r.v, 1'b1, 1'b0, r.d, r.i, r.z, r.c};
	endfunction

endpackage

>>> design/cpu8alu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_if: valid/ready channels of the 8-bit ALU register step
// Command channel (operation and operand) and response channel (result byte
// and the register file after the operation).
// ----------------------------------------------------------------------------
interface cpu8alu_cmd_if;
	logic       valid;
	logic       ready;
	logic [5:0] operation;
	logic [7:0] operand;

	modport source (output valid, output operation, output operand, input ready);
	modport sink (input valid, input operation, input operand, output ready);
endinterface

interface cpu8alu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic [7:0] acc_out;
	logic [7:0] x_out;
	logic [7:0] y_out;
	logic [7:0] sp_out;
	logic [7:0] status_out;

	modport source (
		output valid, output result, output acc_out, output x_out,
		output y_out, output sp_out, output status_out, input ready
	);
	modport sink (
		input valid, input result, input acc_out, input x_out,
		input y_out, input sp_out, input status_out, output ready
	);
endinterface

>>> design/cpu8alu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_exec: single-pass execute logic
// Computes the next register file and the result byte of one operation from
// the current register file, the operation code and the operand.
// ----------------------------------------------------------------------------
module cpu8alu_exec
	import cpu8alu_pkg::*;
(
	input  logic [5:0] operation,
	input  logic [7:0] operand,
	input  regs_t      cur,
	output regs_t      nxt,
	output logic [7:0] result
);

	logic [7:0] add_m;
	logic [8:0] sum;
	logic [7:0] cmp_reg;
	logic [8:0] diff;
	logic [7:0] sh_in;
	logic [7:0] wb;
	logic       mem_op;

	// Shared adder for add and subtract; subtract adds the complement.
	assign add_m = (operation == OP_SBC) ? ~operand : operand;
	assign sum   = {1'b0, cur.acc} + {1'b0, add_m} + {8'd0, cur.c};

	// Shared comparator; bit 8 of the difference is the borrow.
	always_comb begin
		case (operation)
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = cur.acc;
		endcase
	end
	assign diff = {1'b0, cmp_reg} - {1'b0, operand};

	// Odd shift codes work on the operand, even ones on the accumulator.
	assign sh_in = operation[0] ? operand : cur.acc;

	// Main operation decode.
	always_comb begin
		nxt    = cur;
		wb     = 8'd0;
		mem_op = 1'b0;
		case (operation)
			OP_ADC, OP_SBC: begin
				nxt.acc = sum[7:0];
				nxt.c   = sum[8];
				nxt.v   = ~(cur.acc[7] ^ add_m[7]) & (cur.acc[7] ^ sum[7]);
			end
			OP_AND: nxt.acc = cur.acc & operand;
			OP_ORA: nxt.acc = cur.acc | operand;
			OP_EOR: nxt.acc = cur.acc ^ operand;
			OP_BIT: begin
				nxt.n = operand[7];
				nxt.v = operand[6];
				nxt.z = ((operand & cur.acc) == 8'd0);
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.c = ~diff[8];
				wb    = diff[7:0];
			end
			OP_INX: nxt.x = cur.x + 8'd1;
			OP_INY: nxt.y = cur.y + 8'd1;
			OP_DEX: nxt.x = cur.x - 8'd1;
			OP_DEY: nxt.y = cur.y - 8'd1;
			OP_INC_MEM: begin
				wb     = operand + 8'd1;
				mem_op = 1'b1;
			end
			OP_DEC_MEM: begin
				wb     = operand - 8'd1;
				mem_op = 1'b1;
			end
			OP_TAX: nxt.x = cur.acc;
			OP_TAY: nxt.y = cur.acc;
			OP_TXA: nxt.acc = cur.x;
			OP_TXS: nxt.sp = cur.x;
			OP_TYA: nxt.acc = cur.y;
			OP_ASL_A, OP_ASL_MEM: begin
				nxt.c = sh_in[7];
				wb    = {sh_in[6:0], 1'b0};
			end
			OP_LSR_A, OP_LSR_MEM: begin
				nxt.c = sh_in[0];
				wb    = {1'b0, sh_in[7:1]};
			end
			OP_ROL_A, OP_ROL_MEM: begin
				nxt.c = sh_in[7];
				wb    = {sh_in[6:0], cur.c};
			end
			OP_ROR_A, OP_ROR_MEM: begin
				nxt.c = sh_in[0];
				wb    = {cur.c, sh_in[7:1]};
			end
			OP_LDA: nxt.acc = operand;
			OP_LDX: nxt.x = operand;
			OP_LDY: nxt.y = operand;
			OP_LD_STAT: begin
				nxt.n = operand[StatN];
				nxt.v = operand[StatV];
				nxt.d = operand[StatD];
				nxt.i = operand[StatI];
				nxt.z = operand[StatZ];
				nxt.c = operand[StatC];
			end
			OP_SEC: nxt.c = 1'b1;
			OP_SEI: nxt.i = 1'b1;
			OP_CLC: nxt.c = 1'b0;
			OP_CLD: nxt.d = 1'b0;
			default: ;
		endcase

		// Shifts of the accumulator write the shifted byte back to A.
		case (operation)
			OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: nxt.acc = wb;
			OP_ASL_MEM, OP_LSR_MEM, OP_ROL_MEM, OP_ROR_MEM: mem_op = 1'b1;
			default: ;
		endcase

		// N and Z follow the byte that the operation produced.
		case (operation)
			OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR, OP_TXA, OP_TYA, OP_LDA,
			OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
				nxt.n = nxt.acc[7];
				nxt.z = (nxt.acc == 8'd0);
			end
			OP_INX, OP_DEX, OP_TAX, OP_LDX: begin
				nxt.n = nxt.x[7];
				nxt.z = (nxt.x == 8'd0);
			end
			OP_INY, OP_DEY, OP_TAY, OP_LDY: begin
				nxt.n = nxt.y[7];
				nxt.z = (nxt.y == 8'd0);
			end
			OP_CMP, OP_CPX, OP_CPY, OP_INC_MEM, OP_DEC_MEM,
			OP_ASL_MEM, OP_LSR_MEM, OP_ROL_MEM, OP_ROR_MEM: begin
				nxt.n = wb[7];
				nxt.z = (wb == 8'd0);
			end
			default: ;
		endcase
	end

	assign result = mem_op ? wb : nxt.acc;

endmodule

>>> design/cpu8_alu_register_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_register_step_core: execute stage of an 8-bit CPU, binary mode
// Holds A, X, Y, SP and the flags and applies one operation per command beat.
// ----------------------------------------------------------------------------
// A command beat is registered in the command register, executed against the
// register file and moved into the response register, which offers its
// response beat (result byte plus the full register file after the
// operation). One command is taken every cycle as long as the response side
// keeps up; the response register and the command register each hold one
// beat, so a stalled response holds at most one further command. After reset
// A, X, Y and SP are zero and only the I flag is set. Add and subtract are
// binary even with D set.
// ----------------------------------------------------------------------------
module cpu8_alu_register_step_core
	import cpu8alu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	cpu8alu_cmd_if.sink   cmd,
	cpu8alu_rsp_if.source rsp
);

	logic       valid_s1;
	logic [5:0] operation_s1;
	logic [7:0] operand_s1;
	regs_t      regs_q;
	regs_t      regs_nxt;
	logic [7:0] result_nxt;
	logic       valid_s2;
	logic [7:0] result_s2;
	regs_t      regs_s2;
	logic       advance;

	// The executing beat moves on when the response register is free.
	assign advance   = ~valid_s2 | rsp.ready;
	assign cmd.ready = ~valid_s1 | advance;

	// Command register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Command register payload.
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			operation_s1 <= cmd.operation;
			operand_s1   <= cmd.operand;
		end
	end

	cpu8alu_exec u_exec (
		.operation (operation_s1),
		.operand   (operand_s1),
		.cur       (regs_q),
		.nxt       (regs_nxt),
		.result    (result_nxt)
	);

	// Register file commits when the executing beat moves to the response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= RegsReset;
		end else if (valid_s1 && advance) begin
			regs_q <= regs_nxt;
		end
	end

	// Response register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_s2 <= result_nxt;
			regs_s2   <= regs_nxt;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.result     = result_s2;
	assign rsp.acc_out    = regs_s2.acc;
	assign rsp.x_out      = regs_s2.x;
	assign rsp.y_out      = regs_s2.y;
	assign rsp.sp_out     = regs_s2.sp;
	assign rsp.status_out = pack_status(regs_s2);

endmodule

>>> design/cpu8alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_checker: port-level checks of the ALU register step
// Watches the command and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cpu8alu_checker
	import cpu8alu_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_result,
	input logic [7:0] rsp_status_out
);

	// A stalled response beat stays offered.
	a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response valid dropped while stalled");

	// A stalled response beat keeps its result byte.
	a_rsp_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result))
		else $error("response result changed while stalled");

	// A response side that takes beats never stalls the command side.
	a_no_cmd_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> cmd_ready)
		else $error("command stalled with a ready response side");

	// The fixed status bits read as one and zero.
	a_status_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status_out[StatOne] && !rsp_status_out[StatZero])
		else $error("fixed status bits wrong");

endmodule

bind cpu8_alu_register_step_core cpu8alu_checker u_cpu8alu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_result     (rsp.result),
	.rsp_status_out (rsp.status_out)
);

>>> verif/cpu8_alu_register_step_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_register_step_core_test: self-checking bench of the ALU step core
// Feeds directed and random command beats through a valid/ready driver,
// tracks the register file in a local model of the execute stage and
// compares every response beat field by field against it.
// ----------------------------------------------------------------------------
module cpu8_alu_register_step_core_test;
	import cpu8alu_pkg::*;

	// Codes outside the defined operation set; the core must leave state alone.
	localparam logic [5:0] OpUnusedLow = 6'd36;
	localparam logic [5:0] OpUnusedHigh = 6'd63;
	localparam int IdlePercent = 29;
	localparam int RandomCommands = 950;
	localparam int StallLimit = 2000;
	localparam int DrainCycles = 8;

	// One command beat as queued for the driver.
	typedef struct packed {
		logic [5:0] operation;
		logic [7:0] operand;
	} alu_cmd_t;

	// Register file after one operation plus the byte reported as result.
	typedef struct packed {
		regs_t      regs;
		logic [7:0] result;
	} alu_step_t;

	logic clk = 1'b0;
	logic arst_n;

	cpu8alu_cmd_if cmd_ch ();
	cpu8alu_rsp_if rsp_ch ();

	cpu8_alu_register_step_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	alu_cmd_t  cmd_pending[$];
	alu_step_t expected_steps[$];
	regs_t     model_regs;
	int        cmd_beats;
	int        rsp_beats;
	int        mismatch_count;
	int        stall_cycles;
	logic      steady;

	// Neither side idles while the middle stretch of commands goes through.
	assign steady = (cmd_beats >= 400) && (cmd_beats < 600);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Next register file and result byte of one operation.
	function automatic alu_step_t alu_next(input regs_t s, input logic [5:0] op,
			input logic [7:0] m);
		alu_step_t  o;
		logic [8:0] sum;
		logic [7:0] addend;
		logic [7:0] r;
		logic [7:0] shin;
		logic [7:0] cmp_reg;
		logic [7:0] nz_src;
		logic       nz_upd;
		logic       shifted;
		logic       mem_wr;
		o.regs = s;
		r = 8'h00;
		nz_src = 8'h00;
		nz_upd = 1'b0;
		shifted = 1'b0;
		mem_wr = 1'b0;
		shin = op[0] ? m : s.acc;
		cmp_reg = s.acc;
		case (op_e'(op))
			OP_ADC, OP_SBC: begin
				// Binary only: the decimal flag has no effect here.
				addend = (op_e'(op) == OP_SBC) ? ~m : m;
				sum = {1'b0, s.acc} + {1'b0, addend} + {8'h00, s.c};
				r = sum[7:0];
				o.regs.c = sum[8];
				o.regs.v = ~(s.acc[7] ^ addend[7]) & (s.acc[7] ^ r[7]);
				o.regs.acc = r;
				nz_src = r;
				nz_upd = 1'b1;
			end
			OP_AND: begin
				o.regs.acc = s.acc & m;
				nz_src = o.regs.acc;
				nz_upd = 1'b1;
			end
			OP_ORA: begin
				o.regs.acc = s.acc | m;
				nz_src = o.regs.acc;
				nz_upd = 1'b1;
			end
			OP_EOR: begin
				o.regs.acc = s.acc ^ m;
				nz_src = o.regs.acc;
				nz_upd = 1'b1;
			end
			OP_BIT: begin
				o.regs.n = m[7];
				o.regs.v = m[6];
				o.regs.z = ((m & s.acc) == 8'h00);
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				if (op_e'(op) == OP_CPX) begin
					cmp_reg = s.x;
				end else if (op_e'(op) == OP_CPY) begin
					cmp_reg = s.y;
				end
				o.regs.c = (cmp_reg >= m);
				nz_src = cmp_reg - m;
				nz_upd = 1'b1;
			end
			OP_INX: begin
				o.regs.x = s.x + 8'h01;
				nz_src = o.regs.x;
				nz_upd = 1'b1;
			end
			OP_INY: begin
				o.regs.y = s.y + 8'h01;
				nz_src = o.regs.y;
				nz_upd = 1'b1;
			end
			OP_DEX: begin
				o.regs.x = s.x - 8'h01;
				nz_src = o.regs.x;
				nz_upd = 1'b1;
			end
			OP_DEY: begin
				o.regs.y = s.y - 8'h01;
				nz_src = o.regs.y;
				nz_upd = 1'b1;
			end
			OP_INC_MEM: begin
				r = m + 8'h01;
				mem_wr = 1'b1;
				nz_src = r;
				nz_upd = 1'b1;
			end
			OP_DEC_MEM: begin
				r = m - 8'h01;
				mem_wr = 1'b1;
				nz_src = r;
				nz_upd = 1'b1;
			end
			OP_TAX: begin
				o.regs.x = s.acc;
				nz_src = s.acc;
				nz_upd = 1'b1;
			end
			OP_TAY: begin
				o.regs.y = s.acc;
				nz_src = s.acc;
				nz_upd = 1'b1;
			end
			OP_TXA: begin
				o.regs.acc = s.x;
				nz_src = s.x;
				nz_upd = 1'b1;
			end
			OP_TXS: begin
				o.regs.sp = s.x;
			end
			OP_TYA: begin
				o.regs.acc = s.y;
				nz_src = s.y;
				nz_upd = 1'b1;
			end
			OP_ASL_A, OP_ASL_MEM: begin
				o.regs.c = shin[7];
				r = {shin[6:0], 1'b0};
				shifted = 1'b1;
			end
			OP_LSR_A, OP_LSR_MEM: begin
				o.regs.c = shin[0];
				r = {1'b0, shin[7:1]};
				shifted = 1'b1;
			end
			OP_ROL_A, OP_ROL_MEM: begin
				o.regs.c = shin[7];
				r = {shin[6:0], s.c};
				shifted = 1'b1;
			end
			OP_ROR_A, OP_ROR_MEM: begin
				o.regs.c = shin[0];
				r = {s.c, shin[7:1]};
				shifted = 1'b1;
			end
			OP_LDA: begin
				o.regs.acc = m;
				nz_src = m;
				nz_upd = 1'b1;
			end
			OP_LDX: begin
				o.regs.x = m;
				nz_src = m;
				nz_upd = 1'b1;
			end
			OP_LDY: begin
				o.regs.y = m;
				nz_src = m;
				nz_upd = 1'b1;
			end
			OP_LD_STAT: begin
				// Bits 5 and 4 of the operand are dropped.
				o.regs.n = m[StatN];
				o.regs.v = m[StatV];
				o.regs.d = m[StatD];
				o.regs.i = m[StatI];
				o.regs.z = m[StatZ];
				o.regs.c = m[StatC];
			end
			OP_SEC: o.regs.c = 1'b1;
			OP_SEI: o.regs.i = 1'b1;
			OP_CLC: o.regs.c = 1'b0;
			OP_CLD: o.regs.d = 1'b0;
			default: begin
			end
		endcase
		// Odd shift codes work on the operand and write it back.
		if (shifted) begin
			if (op[0]) begin
				mem_wr = 1'b1;
			end else begin
				o.regs.acc = r;
			end
			nz_src = r;
			nz_upd = 1'b1;
		end
		if (nz_upd) begin
			o.regs.n = nz_src[7];
			o.regs.z = (nz_src == 8'h00);
		end
		o.result = mem_wr ? r : o.regs.acc;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at response beat %0d: %s", rsp_beats, msg);
		mismatch_count++;
	endtask

	task automatic queue_cmd(input logic [5:0] op, input logic [7:0] m);
		alu_cmd_t c;
		c.operation = op;
		c.operand = m;
		cmd_pending.push_back(c);
	endtask

	// Command driver: a new beat goes out once the previous one was taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.operation <= 6'd0;
			cmd_ch.operand <= 8'h00;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (cmd_pending.size() != 0 && (steady || $urandom_range(99) >= IdlePercent)) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.operation <= cmd_pending[0].operation;
				cmd_ch.operand <= cmd_pending[0].operand;
				cmd_pending.pop_front();
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady || ($urandom_range(99) >= IdlePercent);
		end
	end

	// Monitor: checks response beats, predicts command beats, runs the watchdog.
	always @(posedge clk or negedge arst_n) begin
		alu_step_t  want;
		alu_step_t  nxt;
		logic [7:0] want_status;
		logic       cmd_fire;
		logic       rsp_fire;
		if (!arst_n) begin
			model_regs = '0;
			model_regs.i = 1'b1;
			cmd_beats = 0;
			rsp_beats = 0;
			stall_cycles = 0;
		end else begin
			cmd_fire = cmd_ch.valid && cmd_ch.ready;
			rsp_fire = rsp_ch.valid && rsp_ch.ready;
			if (rsp_fire) begin
				if (expected_steps.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, result %02h", rsp_ch.result));
				end else begin
					want = expected_steps.pop_front();
					want_status = 8'h00;
					want_status[StatN] = want.regs.n;
					want_status[StatV] = want.regs.v;
					want_status[StatOne] = 1'b1;
					want_status[StatZero] = 1'b0;
					want_status[StatD] = want.regs.d;
					want_status[StatI] = want.regs.i;
					want_status[StatZ] = want.regs.z;
					want_status[StatC] = want.regs.c;
					if (rsp_ch.result !== want.result)
						report_mismatch($sformatf("result %02h, expected %02h",
							rsp_ch.result, want.result));
					if (rsp_ch.acc_out !== want.regs.acc)
						report_mismatch($sformatf("acc_out %02h, expected %02h",
							rsp_ch.acc_out, want.regs.acc));
					if (rsp_ch.x_out !== want.regs.x)
						report_mismatch($sformatf("x_out %02h, expected %02h",
							rsp_ch.x_out, want.regs.x));
					if (rsp_ch.y_out !== want.regs.y)
						report_mismatch($sformatf("y_out %02h, expected %02h",
							rsp_ch.y_out, want.regs.y));
					if (rsp_ch.sp_out !== want.regs.sp)
						report_mismatch($sformatf("sp_out %02h, expected %02h",
							rsp_ch.sp_out, want.regs.sp));
					if (rsp_ch.status_out !== want_status)
						report_mismatch($sformatf("status_out %02h, expected %02h",
							rsp_ch.status_out, want_status));
				end
				rsp_beats++;
			end
			if (cmd_fire) begin
				nxt = alu_next(model_regs, cmd_ch.operation, cmd_ch.operand);
				model_regs = nxt.regs;
				expected_steps.push_back(nxt);
				cmd_beats++;
			end
			if (cmd_fire || rsp_fire) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= StallLimit) begin
				$display("watchdog: no beat accepted for %0d cycles", StallLimit);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [5:0] op;
		logic [7:0] m;
		mismatch_count = 0;
		arst_n = 1'b0;

		// Directed part: every operation at least once, field extremes, overflow and
		// borrow edges, equal compares, rotates through carry, unused codes.
		queue_cmd(OP_LD_STAT, 8'hFF);
		queue_cmd(OP_LDA, 8'h7F);
		queue_cmd(OP_ADC, 8'h00);
		queue_cmd(OP_SBC, 8'h01);
		queue_cmd(OP_CLC, 8'h00);
		queue_cmd(OP_ADC, 8'hFF);
		queue_cmd(OP_SEC, 8'h00);
		queue_cmd(OP_SBC, 8'hFF);
		queue_cmd(OP_AND, 8'h0F);
		queue_cmd(OP_ORA, 8'hF0);
		queue_cmd(OP_EOR, 8'hFF);
		queue_cmd(OP_BIT, 8'hC0);
		queue_cmd(OP_BIT, 8'h00);
		queue_cmd(OP_CMP, 8'h00);
		queue_cmd(OP_LDX, 8'hFF);
		queue_cmd(OP_CPX, 8'hFF);
		queue_cmd(OP_INX, 8'h00);
		queue_cmd(OP_DEX, 8'h00);
		queue_cmd(OP_LDY, 8'h00);
		queue_cmd(OP_CPY, 8'h01);
		queue_cmd(OP_DEY, 8'h00);
		queue_cmd(OP_INY, 8'h00);
		queue_cmd(OP_INC_MEM, 8'hFF);
		queue_cmd(OP_DEC_MEM, 8'h00);
		queue_cmd(OP_TAX, 8'h00);
		queue_cmd(OP_TAY, 8'h00);
		queue_cmd(OP_TXA, 8'h00);
		queue_cmd(OP_TXS, 8'h00);
		queue_cmd(OP_TYA, 8'h00);
		queue_cmd(OP_ASL_A, 8'h00);
		queue_cmd(OP_ASL_MEM, 8'h80);
		queue_cmd(OP_LSR_A, 8'h00);
		queue_cmd(OP_LSR_MEM, 8'h01);
		queue_cmd(OP_ROL_A, 8'h00);
		queue_cmd(OP_ROL_MEM, 8'hFF);
		queue_cmd(OP_ROR_A, 8'h00);
		queue_cmd(OP_ROR_MEM, 8'h01);
		queue_cmd(OP_SEI, 8'h00);
		queue_cmd(OP_CLD, 8'h00);
		queue_cmd(OP_LD_STAT, 8'h00);
		queue_cmd(OpUnusedLow, 8'hAA);
		queue_cmd(OpUnusedHigh, 8'h55);

		// Random part: mostly defined codes, operands biased toward edges.
		for (int k = 0; k < RandomCommands; k++) begin
			if ($urandom_range(99) < 5) begin
				op = 6'($urandom_range(63, 36));
			end else begin
				op = 6'($urandom_range(35, 0));
			end
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(4))
					0: m = 8'h00;
					1: m = 8'hFF;
					2: m = 8'h7F;
					3: m = 8'h80;
					default: m = 8'h01;
				endcase
			end else begin
				m = 8'($urandom_range(255));
			end
			queue_cmd(op, m);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last command to be taken and its response to arrive.
		while (cmd_pending.size() != 0 || cmd_ch.valid || expected_steps.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (expected_steps.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_steps.size()));

		$display("Ran %0d command beats (directed edges, then random codes incl. unused).",
			cmd_beats);
		$display("Compared %0d response beats field by field, %0d mismatches.",
			rsp_beats, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
